[rtl/core/hoas_pkg.sv]
// hoas_pkg: shared types, codes and constants of the homing oscillating
// axis sequencer. No dependencies; every other file uses it by scoped names.
package hoas_pkg;

	// fixed field widths
	localparam int POS_W = 13;
	localparam int SPD_W = 12;
	localparam int CUR_W = 14;
	localparam int CNT_W = 3;
	localparam int VEL_W = 13;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 13;
	localparam int IN_TDATA_W = 24;
	localparam int OUT_TDATA_W = 64;
	localparam int OUT_USED_W = 59;

	// parameter defaults
	localparam int POSITION_BITS_DEF = 13;
	localparam int END_STEP_DEF = 500;
	localparam int SPEED_STEP_DEF = 100;

	// register reset values
	localparam logic [POS_W-1:0] END_MIN_RST = 13'd2000;
	localparam logic [POS_W-1:0] END_MAX_RST = 13'd5000;
	localparam logic [SPD_W-1:0] SPD_MIN_RST = 12'd500;
	localparam logic [SPD_W-1:0] SPD_MAX_RST = 12'd1500;
	localparam logic [POS_W-1:0] ORIGIN_RST = 13'd200;
	localparam logic [SPD_W-1:0] HOME_SPD_RST = 12'd1000;
	localparam logic [POS_W-1:0] OC_MA_RST = 13'd800;
	localparam logic [CNT_W-1:0] OC_TRIPS_RST = 3'd4;

	// state reset values
	localparam logic [POS_W-1:0] END_POS_RST = 13'd2000;
	localparam logic [SPD_W-1:0] RUN_SPD_RST = 12'd500;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_END_MIN  = 3'd0,
		CFG_END_MAX  = 3'd1,
		CFG_SPD_MIN  = 3'd2,
		CFG_SPD_MAX  = 3'd3,
		CFG_ORIGIN   = 3'd4,
		CFG_HOME_SPD = 3'd5,
		CFG_OC_MA    = 3'd6,
		CFG_OC_TRIPS = 3'd7
	} cfg_idx_t;

	typedef enum logic [2:0] {
		PH_UNHOMED  = 3'd0,
		PH_SEEK_LO  = 3'd1,
		PH_SEEK_UP  = 3'd2,
		PH_HOME_RET = 3'd3,
		PH_READY    = 3'd4,
		PH_FORWARD  = 3'd5,
		PH_BACK     = 3'd6,
		PH_STOP_RET = 3'd7
	} phase_t;

	typedef enum logic [1:0] {
		MODE_STOP = 2'd0,
		MODE_VEL  = 2'd1,
		MODE_MOVE = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		FLT_NONE  = 2'd0,
		FLT_OC    = 2'd1,
		FLT_LIMIT = 2'd2
	} fault_t;

	typedef struct packed {
		logic [POS_W-1:0] end_min;
		logic [POS_W-1:0] end_max;
		logic [SPD_W-1:0] spd_min;
		logic [SPD_W-1:0] spd_max;
		logic [POS_W-1:0] origin;
		logic [SPD_W-1:0] home_spd;
		logic [POS_W-1:0] oc_ma;
		logic [CNT_W-1:0] oc_trips;
	} cfg_t;

	typedef struct packed {
		phase_t           phase;
		logic             lower_seen;
		logic [CNT_W-1:0] oc_count;
		logic [POS_W-1:0] end_pos;
		logic [SPD_W-1:0] run_speed;
	} seq_state_t;

	typedef struct packed {
		logic                    zero_press;
		logic                    start_press;
		logic                    stop_press;
		logic                    end_up_press;
		logic                    end_down_press;
		logic                    speed_up_press;
		logic                    speed_down_press;
		logic                    lower_switch_hit;
		logic                    upper_switch_hit;
		logic signed [CUR_W-1:0] current_sample;
		logic                    at_target;
	} in_item_t;

	typedef struct packed {
		mode_t                   motion_mode;
		logic signed [VEL_W-1:0] drive_velocity;
		logic [POS_W-1:0]        target_position;
		logic                    zero_position_now;
		phase_t                  state_code;
		fault_t                  fault_code;
		logic [POS_W-1:0]        end_position_now;
		logic [SPD_W-1:0]        run_speed_now;
	} out_item_t;

endpackage

[rtl/core/hoas_cfg.sv]
// hoas_cfg: configuration register file, written through the config channel.
// Depends on hoas_pkg.
module hoas_cfg (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  wr_en,
	input  logic [hoas_pkg::CFG_IDX_W-1:0]        wr_index,
	input  logic [hoas_pkg::CFG_DATA_W-1:0]       wr_data,
	output hoas_pkg::cfg_t                        cfg
);

	hoas_pkg::cfg_t cfg_q;

	// one register per index, narrower registers take the low bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.end_min  <= hoas_pkg::END_MIN_RST;
			cfg_q.end_max  <= hoas_pkg::END_MAX_RST;
			cfg_q.spd_min  <= hoas_pkg::SPD_MIN_RST;
			cfg_q.spd_max  <= hoas_pkg::SPD_MAX_RST;
			cfg_q.origin   <= hoas_pkg::ORIGIN_RST;
			cfg_q.home_spd <= hoas_pkg::HOME_SPD_RST;
			cfg_q.oc_ma    <= hoas_pkg::OC_MA_RST;
			cfg_q.oc_trips <= hoas_pkg::OC_TRIPS_RST;
		end else if (wr_en) begin
			unique case (hoas_pkg::cfg_idx_t'(wr_index))
				hoas_pkg::CFG_END_MIN:  cfg_q.end_min  <= wr_data[hoas_pkg::POS_W-1:0];
				hoas_pkg::CFG_END_MAX:  cfg_q.end_max  <= wr_data[hoas_pkg::POS_W-1:0];
				hoas_pkg::CFG_SPD_MIN:  cfg_q.spd_min  <= wr_data[hoas_pkg::SPD_W-1:0];
				hoas_pkg::CFG_SPD_MAX:  cfg_q.spd_max  <= wr_data[hoas_pkg::SPD_W-1:0];
				hoas_pkg::CFG_ORIGIN:   cfg_q.origin   <= wr_data[hoas_pkg::POS_W-1:0];
				hoas_pkg::CFG_HOME_SPD: cfg_q.home_spd <= wr_data[hoas_pkg::SPD_W-1:0];
				hoas_pkg::CFG_OC_MA:    cfg_q.oc_ma    <= wr_data[hoas_pkg::POS_W-1:0];
				hoas_pkg::CFG_OC_TRIPS: cfg_q.oc_trips <= wr_data[hoas_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/core/hoas_step.sv]
// hoas_step: combinational tick logic, sequencer state and one item in,
// next state and one result out. Depends on hoas_pkg.
module hoas_step #(
	parameter int POSITION_BITS = hoas_pkg::POSITION_BITS_DEF,
	parameter int END_STEP      = hoas_pkg::END_STEP_DEF,
	parameter int SPEED_STEP    = hoas_pkg::SPEED_STEP_DEF
) (
	input  hoas_pkg::cfg_t       cfg,
	input  hoas_pkg::seq_state_t cur_st,
	input  hoas_pkg::in_item_t   item,
	output hoas_pkg::seq_state_t nxt_st,
	output hoas_pkg::out_item_t  res
);

	localparam int PW = hoas_pkg::POS_W;
	localparam int SW = hoas_pkg::SPD_W;
	localparam int CW = hoas_pkg::CNT_W;

	function automatic logic [PW-1:0] tgt_mask();
		logic [PW-1:0] m;
		for (int i = 0; i < PW; i++) begin
			m[i] = (i < POSITION_BITS);
		end
		return m;
	endfunction

	localparam logic [PW-1:0] TGT_MASK = tgt_mask();
	localparam logic [PW:0]   END_STEP_X = (PW+1)'(END_STEP);
	localparam logic [SW:0]   SPD_STEP_X = (SW+1)'(SPEED_STEP);

	hoas_pkg::phase_t  ph;
	hoas_pkg::fault_t  fault;
	logic              ls;
	logic [CW-1:0]     cnt;
	logic [CW:0]       cnt_inc;
	logic [PW-1:0]     ep;
	logic [SW-1:0]     rs;
	logic [PW:0]       ep_sum;
	logic [SW:0]       rs_sum;
	logic              zero_now;
	logic              over;

	assign over = item.current_sample > $signed({1'b0, cfg.oc_ma});
	assign cnt_inc = {1'b0, cur_st.oc_count} + (CW+1)'(1);

	// phase transitions, in the order a tick is evaluated
	always_comb begin
		ph       = cur_st.phase;
		ls       = cur_st.lower_seen;
		cnt      = cur_st.oc_count;
		ep       = cur_st.end_pos;
		rs       = cur_st.run_speed;
		fault    = hoas_pkg::FLT_NONE;
		zero_now = 1'b0;
		ep_sum   = '0;
		rs_sum   = '0;

		if (ph == hoas_pkg::PH_UNHOMED && item.zero_press) begin
			ph = hoas_pkg::PH_SEEK_LO;
		end
		if (ph == hoas_pkg::PH_SEEK_LO && item.lower_switch_hit) begin
			zero_now = 1'b1;
			ls       = 1'b1;
			ph       = hoas_pkg::PH_SEEK_UP;
		end

		priority if (ph == hoas_pkg::PH_SEEK_UP && item.upper_switch_hit && ls) begin
			ph = hoas_pkg::PH_HOME_RET;
		end else if (ph == hoas_pkg::PH_HOME_RET && item.at_target) begin
			ph = hoas_pkg::PH_READY;
		end else if (ph == hoas_pkg::PH_READY) begin
			// adjust presses, up clamps to max, down clamps to min
			if (item.end_up_press) begin
				ep_sum = {1'b0, ep} + END_STEP_X;
				ep = (ep_sum > {1'b0, cfg.end_max}) ? cfg.end_max : ep_sum[PW-1:0];
			end
			if (item.end_down_press) begin
				ep_sum = {1'b0, cfg.end_min} + END_STEP_X;
				ep = ({1'b0, ep} < ep_sum) ? cfg.end_min : (ep - END_STEP_X[PW-1:0]);
			end
			if (item.speed_up_press) begin
				rs_sum = {1'b0, rs} + SPD_STEP_X;
				rs = (rs_sum > {1'b0, cfg.spd_max}) ? cfg.spd_max : rs_sum[SW-1:0];
			end
			if (item.speed_down_press) begin
				rs_sum = {1'b0, cfg.spd_min} + SPD_STEP_X;
				rs = ({1'b0, rs} < rs_sum) ? cfg.spd_min : (rs - SPD_STEP_X[SW-1:0]);
			end
			if (item.start_press) begin
				ph = hoas_pkg::PH_FORWARD;
			end
		end else if (ph == hoas_pkg::PH_FORWARD || ph == hoas_pkg::PH_BACK) begin
			// reversal, then over-current, then stop, then limit switches
			if (item.at_target) begin
				ph = (ph == hoas_pkg::PH_FORWARD) ? hoas_pkg::PH_BACK : hoas_pkg::PH_FORWARD;
			end
			if (over) begin
				if (cnt_inc > {1'b0, cfg.oc_trips}) begin
					fault = hoas_pkg::FLT_OC;
					ph    = hoas_pkg::PH_UNHOMED;
					ls    = 1'b0;
					cnt   = '0;
				end else begin
					cnt = cnt_inc[CW-1:0];
				end
			end else begin
				cnt = '0;
			end
			if (fault == hoas_pkg::FLT_NONE) begin
				if (item.stop_press) begin
					ph = hoas_pkg::PH_STOP_RET;
				end else if (item.lower_switch_hit || item.upper_switch_hit) begin
					fault = hoas_pkg::FLT_LIMIT;
					ph    = hoas_pkg::PH_UNHOMED;
					ls    = 1'b0;
					cnt   = '0;
				end
			end
		end else if (ph == hoas_pkg::PH_STOP_RET && item.at_target) begin
			ph = hoas_pkg::PH_READY;
		end else begin
			ph = ph;
		end
	end

	// motion command for the phase after the tick
	always_comb begin
		res.motion_mode     = hoas_pkg::MODE_STOP;
		res.drive_velocity  = '0;
		res.target_position = '0;
		unique case (ph)
			hoas_pkg::PH_SEEK_LO: begin
				res.motion_mode    = hoas_pkg::MODE_VEL;
				res.drive_velocity = -$signed({1'b0, cfg.home_spd});
			end
			hoas_pkg::PH_SEEK_UP: begin
				res.motion_mode    = hoas_pkg::MODE_VEL;
				res.drive_velocity = $signed({1'b0, cfg.home_spd});
			end
			hoas_pkg::PH_HOME_RET, hoas_pkg::PH_STOP_RET: begin
				res.motion_mode     = hoas_pkg::MODE_MOVE;
				res.drive_velocity  = $signed({1'b0, cfg.home_spd});
				res.target_position = cfg.origin & TGT_MASK;
			end
			hoas_pkg::PH_FORWARD: begin
				res.motion_mode     = hoas_pkg::MODE_MOVE;
				res.drive_velocity  = $signed({1'b0, rs});
				res.target_position = ep & TGT_MASK;
			end
			hoas_pkg::PH_BACK: begin
				res.motion_mode     = hoas_pkg::MODE_MOVE;
				res.drive_velocity  = $signed({1'b0, rs});
				res.target_position = cfg.origin & TGT_MASK;
			end
			default: ;
		endcase
		res.zero_position_now = zero_now;
		res.state_code        = ph;
		res.fault_code        = fault;
		res.end_position_now  = ep;
		res.run_speed_now     = rs;
	end

	assign nxt_st.phase      = ph;
	assign nxt_st.lower_seen = ls;
	assign nxt_st.oc_count   = cnt;
	assign nxt_st.end_pos    = ep;
	assign nxt_st.run_speed  = rs;

endmodule

[rtl/core/homing_oscillating_axis_sequencer.sv]
// homing_oscillating_axis_sequencer: top level, input register, sequencer
// state, result register. Depends on hoas_pkg, hoas_cfg and hoas_step.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+----------------------------
//  s_axis   | in        | s_axis_tvalid/tready   | s_axis_tdata, one tick
//  m_axis   | out       | m_axis_tvalid/tready   | m_axis_tdata, one result
//  cfg      | in        | cfg_valid/cfg_ready    | cfg_index, cfg_data
//
// One result per tick. A tick is held in the input register, then its result
// is registered in the result register and offered from there; one tick is
// accepted every cycle while the result side keeps up.
// Reset loads the config registers and state with their reset values and clears both valid flags at once.
// A stalled result holds; the input register then fills and tready drops.
// Config writes are always accepted.
module homing_oscillating_axis_sequencer #(
	parameter int POSITION_BITS = hoas_pkg::POSITION_BITS_DEF,
	parameter int END_STEP      = hoas_pkg::END_STEP_DEF,
	parameter int SPEED_STEP    = hoas_pkg::SPEED_STEP_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// [0] zero_press [1] start_press [2] stop_press [3] end_up_press
	// [4] end_down_press [5] speed_up_press [6] speed_down_press
	// [7] lower_switch_hit [8] upper_switch_hit [22:9] current_sample
	// [23] at_target
	input  logic [hoas_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// [1:0] motion_mode [14:2] drive_velocity [27:15] target_position
	// [28] zero_position_now [31:29] state_code [33:32] fault_code
	// [46:34] end_position_now [58:47] run_speed_now [63:59] zero
	output logic [hoas_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [hoas_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [hoas_pkg::CFG_DATA_W-1:0]      cfg_data
);

	hoas_pkg::cfg_t       cfg;
	hoas_pkg::seq_state_t st_q;
	hoas_pkg::seq_state_t st_nxt;
	hoas_pkg::in_item_t   item_s1;
	hoas_pkg::in_item_t   item_in;
	hoas_pkg::out_item_t  res;
	hoas_pkg::out_item_t  res_s2;
	logic                 valid_s1;
	logic                 valid_s2;
	logic                 advance;

	assign cfg_ready = 1'b1;

	hoas_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// unpack the input transfer
	assign item_in.zero_press       = s_axis_tdata[0];
	assign item_in.start_press      = s_axis_tdata[1];
	assign item_in.stop_press       = s_axis_tdata[2];
	assign item_in.end_up_press     = s_axis_tdata[3];
	assign item_in.end_down_press   = s_axis_tdata[4];
	assign item_in.speed_up_press   = s_axis_tdata[5];
	assign item_in.speed_down_press = s_axis_tdata[6];
	assign item_in.lower_switch_hit = s_axis_tdata[7];
	assign item_in.upper_switch_hit = s_axis_tdata[8];
	assign item_in.current_sample   = $signed(s_axis_tdata[22:9]);
	assign item_in.at_target        = s_axis_tdata[23];

	// handshake: the tick moves on when the result register is free or draining
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1 <= item_in;
		end
	end

	hoas_step #(
		.POSITION_BITS (POSITION_BITS),
		.END_STEP      (END_STEP),
		.SPEED_STEP    (SPEED_STEP)
	) u_step (
		.cfg    (cfg),
		.cur_st (st_q),
		.item   (item_s1),
		.nxt_st (st_nxt),
		.res    (res)
	);

	// sequencer state commits with each tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase      <= hoas_pkg::PH_UNHOMED;
			st_q.lower_seen <= 1'b0;
			st_q.oc_count   <= '0;
			st_q.end_pos    <= hoas_pkg::END_POS_RST;
			st_q.run_speed  <= hoas_pkg::RUN_SPD_RST;
		end else if (advance) begin
			st_q <= st_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {
		{(hoas_pkg::OUT_TDATA_W - hoas_pkg::OUT_USED_W){1'b0}},
		res_s2.run_speed_now,
		res_s2.end_position_now,
		res_s2.fault_code,
		res_s2.state_code,
		res_s2.zero_position_now,
		res_s2.target_position,
		res_s2.drive_velocity,
		res_s2.motion_mode
	};

endmodule

[rtl/core/hoas_checker.sv]
// hoas_checker: port-level assertions on the sequencer results, bound to
// the top level. Depends on hoas_pkg and homing_oscillating_axis_sequencer.
module hoas_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              m_axis_tvalid,
	input logic                              m_axis_tready,
	input logic [hoas_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

	logic [1:0]  mode;
	logic [12:0] vel;
	logic [12:0] tgt;
	logic        zero_now;
	logic [2:0]  state;
	logic [1:0]  fault;

	assign mode     = m_axis_tdata[1:0];
	assign vel      = m_axis_tdata[14:2];
	assign tgt      = m_axis_tdata[27:15];
	assign zero_now = m_axis_tdata[28];
	assign state    = m_axis_tdata[31:29];
	assign fault    = m_axis_tdata[33:32];

	// a result not taken stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	// any fault leaves the sequencer unhomed and stopped
	a_fault_unhomed: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && fault != hoas_pkg::FLT_NONE |->
		state == hoas_pkg::PH_UNHOMED && mode == hoas_pkg::MODE_STOP)
		else $error("fault without return to unhomed");

	// stop mode carries zero velocity and zero target
	a_stop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && mode == hoas_pkg::MODE_STOP |-> vel == '0 && tgt == '0)
		else $error("stop mode with motion fields set");

	// position zeroing only on the lower switch during homing
	a_zero_homing: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && zero_now |->
		state == hoas_pkg::PH_SEEK_UP || state == hoas_pkg::PH_HOME_RET)
		else $error("position zeroed outside homing");

endmodule

bind homing_oscillating_axis_sequencer hoas_checker u_hoas_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
